/* rtl/bvp_pkg.sv */
// ----------------------------------------------------------------------------
// bvp_pkg
// Shared types and constants for the battery voltage to percent pipeline.
// ----------------------------------------------------------------------------
package bvp_pkg;

    localparam int NPOINTS   = 6;
    localparam int TBL_W     = 13;   // built-in breakpoints fit in 13 bits
    localparam int NUM_PRESETS = 4;
    localparam int REG_IDX_W = 3;

    // quotient magnitude bits; anything at or above 2**QUO_BITS saturates
    localparam int QUO_BITS      = 8;
    localparam int QUO_PER_STAGE = 2;

    localparam int PCT_MAX  = 100;
    localparam int PCT_STEP = 20;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_PRESET   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FULL_MV  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EMPTY_MV = 3'd6;

    // preset codes; 5..7 fall back to the custom registers
    localparam logic [2:0] PRESET_CUSTOM  = 3'd0;
    localparam logic [2:0] PRESET_LITHIUM = 3'd1;
    localparam logic [2:0] PRESET_NIMH4   = 3'd4;

    // rows: lithium, alkaline three cell, nickel three cell, nickel four cell
    // columns: 100, 80, 60, 40, 20, 0 percent
    localparam logic [TBL_W-1:0] BUILTIN_MV [NUM_PRESETS][NPOINTS] = '{
        '{13'd4200, 13'd3950, 13'd3850, 13'd3750, 13'd3700, 13'd2800},
        '{13'd4650, 13'd4050, 13'd3870, 13'd3690, 13'd3570, 13'd3300},
        '{13'd4200, 13'd3810, 13'd3750, 13'd3690, 13'd3600, 13'd3000},
        '{13'd5600, 13'd5080, 13'd5000, 13'd4920, 13'd4800, 13'd4000}
    };

    // sideband carried alongside the division
    typedef struct packed {
        logic [6:0] pa;          // percent at the segment's upper breakpoint
        logic       neg;         // quotient sign
        logic       zero_width;  // equal breakpoints, no division
    } bvp_side_t;

endpackage

/* rtl/bvp_divider.sv */
// ----------------------------------------------------------------------------
// bvp_divider
// Pipelined restoring divider, two quotient bits per stage, saturating
// magnitude quotient. Each stage has its own valid bit and stall logic.
// ----------------------------------------------------------------------------
module bvp_divider import bvp_pkg::*; #(
    parameter int DEN_W = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DEN_W+4:0]     in_num,
    input  logic [DEN_W-1:0]     in_den,
    input  bvp_side_t            in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [QUO_BITS-1:0]  out_quo,
    output bvp_side_t            out_side
);

    localparam int REM_W = DEN_W + QUO_BITS;
    localparam int NSTG  = QUO_BITS / QUO_PER_STAGE;

    logic [REM_W-1:0]    rem_reg  [NSTG];
    logic [DEN_W-1:0]    den_reg  [NSTG];
    logic [QUO_BITS-1:0] quo_reg  [NSTG];
    logic                ovf_reg  [NSTG];
    bvp_side_t           side_reg [NSTG];
    logic                valid_reg[NSTG];

    logic [REM_W-1:0]    rem_in  [NSTG];
    logic [DEN_W-1:0]    den_in  [NSTG];
    logic [QUO_BITS-1:0] quo_in  [NSTG];
    logic                ovf_in  [NSTG];
    bvp_side_t           side_in [NSTG];
    logic                valid_in[NSTG];
    logic                stg_ready[NSTG];

    // stage inputs: first stage from the ports, the rest from the stage above
    always_comb begin
        for (int s = 0; s < NSTG; s++) begin
            if (s == 0) begin
                rem_in[s]   = REM_W'(in_num);
                den_in[s]   = in_den;
                quo_in[s]   = '0;
                ovf_in[s]   = REM_W'(in_num) >= (REM_W'(in_den) << QUO_BITS);
                side_in[s]  = in_side;
                valid_in[s] = in_valid;
            end else begin
                rem_in[s]   = rem_reg[s-1];
                den_in[s]   = den_reg[s-1];
                quo_in[s]   = quo_reg[s-1];
                ovf_in[s]   = ovf_reg[s-1];
                side_in[s]  = side_reg[s-1];
                valid_in[s] = valid_reg[s-1];
            end
        end
    end

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic [REM_W-1:0]    rem_next;
        logic [QUO_BITS-1:0] quo_next;
        logic                down_ready;

        if (s == NSTG - 1) begin : g_last
            assign down_ready = out_ready;
        end else begin : g_mid
            assign down_ready = stg_ready[s+1];
        end
        assign stg_ready[s] = !valid_reg[s] || down_ready;

        always_comb begin
            logic [REM_W-1:0] dsh;
            rem_next = rem_in[s];
            quo_next = quo_in[s];
            for (int j = 0; j < QUO_PER_STAGE; j++) begin
                dsh = REM_W'(den_in[s]) << (QUO_BITS - 1 - QUO_PER_STAGE * s - j);
                if (rem_next >= dsh) begin
                    rem_next = rem_next - dsh;
                    quo_next[QUO_BITS - 1 - QUO_PER_STAGE * s - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (stg_ready[s]) begin
                valid_reg[s] <= valid_in[s];
            end
            if (stg_ready[s] && valid_in[s]) begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_in[s];
                quo_reg[s]  <= quo_next;
                ovf_reg[s]  <= ovf_in[s];
                side_reg[s] <= side_in[s];
            end
        end
    end

    assign in_ready  = stg_ready[0];
    assign out_valid = valid_reg[NSTG-1];
    assign out_quo   = ovf_reg[NSTG-1] ? '1 : quo_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

/* rtl/battery_voltage_to_percent.sv */
// ----------------------------------------------------------------------------
// battery_voltage_to_percent
// Piecewise linear battery state of charge from a millivolt reading.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output is not stalled;
//   every stage has its own valid bit, so bubbles collapse and a stalled
//   output does not block empty stages.
// The divider contributes 4 stages of 2 quotient bits each.
// Reset (aresetn, synchronous, active low): pipeline emptied, preset = custom,
//   custom breakpoints = 4200/3950/3850/3750/3700/2800 mV.
module battery_voltage_to_percent import bvp_pkg::*; #(
    parameter int VOLT_BITS = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [VOLT_BITS-1:0]  cfg_data,
    // input samples
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VOLT_BITS-1:0]  s_millivolts,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [6:0]            m_percent,
    output logic                  m_zero_width
);

    // Breakpoints are kept wide enough for the built-in tables even when
    // VOLT_BITS is narrower than those values.
    localparam int PT_W = (VOLT_BITS > TBL_W) ? VOLT_BITS : TBL_W;
    localparam int NUM_W = PT_W + 5;   // 20 * |a - v|

    // ------------------------------------------------------------------
    // Configuration registers. Always ready; writes to unused indexes drop.
    // ------------------------------------------------------------------
    logic [2:0]      preset_reg;
    logic [PT_W-1:0] custom_reg [NPOINTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preset_reg <= PRESET_CUSTOM;
            for (int i = 0; i < NPOINTS; i++) begin
                custom_reg[i] <= PT_W'(BUILTIN_MV[0][i]);
            end
        end else if (cfg_valid) begin
            if (cfg_index == REG_PRESET) begin
                preset_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < NPOINTS; i++) begin
                if (cfg_index == REG_IDX_W'(REG_FULL_MV + i)) begin
                    custom_reg[i] <= PT_W'(cfg_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick breakpoints, choose the segment, latch v / a / b / pa.
    // ------------------------------------------------------------------
    logic [PT_W-1:0] pts [NPOINTS];
    logic            use_tbl;
    logic [1:0]      tbl_sel;
    logic [PT_W-1:0] v_in;
    logic [PT_W-1:0] a_next, b_next;
    logic [6:0]      pa_next;

    logic            p1_valid_reg;
    logic [PT_W-1:0] p1_v_reg, p1_a_reg, p1_b_reg;
    logic [6:0]      p1_pa_reg;
    logic            p1_ready, p2_ready;

    always_comb begin
        use_tbl = (preset_reg >= PRESET_LITHIUM) && (preset_reg <= PRESET_NIMH4);
        tbl_sel = 2'(preset_reg - PRESET_LITHIUM);
        for (int i = 0; i < NPOINTS; i++) begin
            pts[i] = use_tbl ? PT_W'(BUILTIN_MV[tbl_sel][i]) : custom_reg[i];
        end
    end

    assign v_in = PT_W'(s_millivolts);

    // upper-inclusive bands; top band is strictly above the 80 point
    always_comb begin
        if (v_in > pts[1]) begin
            a_next = pts[0]; b_next = pts[1]; pa_next = 7'(PCT_MAX);
        end else if (v_in > pts[2]) begin
            a_next = pts[1]; b_next = pts[2]; pa_next = 7'(PCT_MAX - PCT_STEP);
        end else if (v_in > pts[3]) begin
            a_next = pts[2]; b_next = pts[3]; pa_next = 7'(PCT_MAX - 2 * PCT_STEP);
        end else if (v_in > pts[4]) begin
            a_next = pts[3]; b_next = pts[4]; pa_next = 7'(PCT_MAX - 3 * PCT_STEP);
        end else begin
            a_next = pts[4]; b_next = pts[5]; pa_next = 7'(PCT_MAX - 4 * PCT_STEP);
        end
    end

    assign p1_ready = !p1_valid_reg || p2_ready;
    assign s_ready  = p1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_ready) begin
            p1_valid_reg <= s_valid;
        end
        if (p1_ready && s_valid) begin
            p1_v_reg  <= v_in;
            p1_a_reg  <= a_next;
            p1_b_reg  <= b_next;
            p1_pa_reg <= pa_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: signed differences -> magnitudes and quotient sign.
    // pct = 20*(a-v)/(b-a) + pa, truncated toward zero.
    // ------------------------------------------------------------------
    logic signed [PT_W:0] av_diff, ba_diff;
    logic [PT_W-1:0]      av_abs, ba_abs;
    logic [NUM_W-1:0]     num_next;
    bvp_side_t            side_next;

    logic                 p2_valid_reg;
    logic [NUM_W-1:0]     p2_num_reg;
    logic [PT_W-1:0]      p2_den_reg;
    bvp_side_t            p2_side_reg;
    logic                 div_in_ready;

    always_comb begin
        av_diff = $signed({1'b0, p1_a_reg}) - $signed({1'b0, p1_v_reg});
        ba_diff = $signed({1'b0, p1_b_reg}) - $signed({1'b0, p1_a_reg});
        av_abs  = av_diff[PT_W] ? PT_W'(-av_diff) : PT_W'(av_diff);
        ba_abs  = ba_diff[PT_W] ? PT_W'(-ba_diff) : PT_W'(ba_diff);
        // x20 = x16 + x4
        num_next = (NUM_W'(av_abs) << 4) + (NUM_W'(av_abs) << 2);
        side_next.pa         = p1_pa_reg;
        side_next.neg        = av_diff[PT_W] ^ ba_diff[PT_W];
        side_next.zero_width = (ba_diff == '0);
    end

    assign p2_ready = !p2_valid_reg || div_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_ready) begin
            p2_valid_reg <= p1_valid_reg;
        end
        if (p2_ready && p1_valid_reg) begin
            p2_num_reg  <= num_next;
            p2_den_reg  <= ba_abs;
            p2_side_reg <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3..6: divider (saturating 8-bit magnitude quotient).
    // ------------------------------------------------------------------
    logic                div_out_valid;
    logic [QUO_BITS-1:0] div_quo;
    bvp_side_t           div_side;
    logic                out_ld;

    bvp_divider #(
        .DEN_W (PT_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p2_valid_reg),
        .in_ready  (div_in_ready),
        .in_num    (p2_num_reg),
        .in_den    (p2_den_reg),
        .in_side   (p2_side_reg),
        .out_valid (div_out_valid),
        .out_ready (out_ld),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Stage 7: apply sign, add pa, clamp to 0..100. This is the output reg.
    // ------------------------------------------------------------------
    logic signed [9:0] pct_sum;
    logic [6:0]        pct_next;
    logic              m_valid_reg;
    logic [6:0]        m_percent_reg;
    logic              m_zero_width_reg;

    always_comb begin
        if (div_side.neg) begin
            pct_sum = $signed({3'b000, div_side.pa}) - $signed({2'b00, div_quo});
        end else begin
            pct_sum = $signed({3'b000, div_side.pa}) + $signed({2'b00, div_quo});
        end
        if (div_side.zero_width) begin
            pct_next = div_side.pa;
        end else if (pct_sum < 0) begin
            pct_next = '0;
        end else if (pct_sum > 10'sd100) begin
            pct_next = 7'(PCT_MAX);
        end else begin
            pct_next = pct_sum[6:0];
        end
    end

    assign out_ld = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ld) begin
            m_valid_reg <= div_out_valid;
        end
        if (out_ld && div_out_valid) begin
            m_percent_reg    <= pct_next;
            m_zero_width_reg <= div_side.zero_width;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_percent    = m_percent_reg;
    assign m_zero_width = m_zero_width_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // result never leaves the clamp range
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_percent <= 7'd100))
        else $error("percent above 100");

    // zero-width result is always a segment's upper percent
    a_zw_pct: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_width) |->
            (m_percent == 7'd100 || m_percent == 7'd80 || m_percent == 7'd60 ||
             m_percent == 7'd40 || m_percent == 7'd20))
        else $error("zero-width result with odd percent");

    // stalled first stage keeps its item
    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p2_ready) |=>
            (p1_valid_reg && $stable(p1_v_reg) && $stable(p1_a_reg)))
        else $error("stage 1 item lost under stall");

    // zero-width flag agrees with the denominator
    a_p2_zw: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg |-> (p2_side_reg.zero_width == (p2_den_reg == '0)))
        else $error("zero-width flag mismatch");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for battery_voltage_to_percent. Millivolt samples go
// into the input channel, and a scoreboard predicts each charge percentage.
// The prediction covers segment choice, interpolation with the quotient
// truncated toward zero, clamping and the zero-width flag. Results are
// compared in order, field by field. Breakpoint tables are changed between
// phases while the pipeline is empty. Both sides insert random idle cycles,
// and two long output stalls force input backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOLT_BITS = 14;
    localparam int VOLT_MAX  = (1 << VOLT_BITS) - 1;
    localparam int IDX_W     = bvp_pkg::REG_IDX_W;
    localparam int NUM_BP    = 6;

    localparam int PCT_FULL = 100;
    localparam int PCT_BAND = 20;

    // register map
    localparam logic [IDX_W-1:0] IDX_PRESET = 3'd0;
    localparam logic [IDX_W-1:0] IDX_FULL   = 3'd1;
    localparam logic [IDX_W-1:0] IDX_AT20   = 3'd5;
    localparam logic [IDX_W-1:0] IDX_EMPTY  = 3'd6;
    localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;

    // preset codes; 5..7 are reserved and fall back to the custom registers
    localparam logic [2:0] CHEM_CUSTOM   = 3'd0;
    localparam logic [2:0] CHEM_LITHIUM  = 3'd1;
    localparam logic [2:0] CHEM_NIMH4    = 3'd4;
    localparam logic [2:0] CHEM_RESERVED = 3'd5;

    localparam int NUM_PHASES      = 38;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 1000;

    // breakpoint table shapes for the random phases
    typedef enum int {
        SHAPE_RESET,
        SHAPE_ORDERED,
        SHAPE_SCRAMBLED,
        SHAPE_ZERO,
        SHAPE_MAX,
        SHAPE_CLUSTER
    } bp_shape_t;

    typedef struct {
        logic [6:0] percent;
        logic       zero_width;
    } charge_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the registers, predicted charge per sample,
    // in-order compare against the result channel.
    // ------------------------------------------------------------------------
    class charge_scoreboard;
        int          chem_mv [4][NUM_BP];
        int          custom_mv [NUM_BP];
        logic [2:0]  preset_sel;
        charge_t     expected_charge [$];
        int          mismatches;

        function new();
            chem_mv = '{
                '{4200, 3950, 3850, 3750, 3700, 2800},
                '{4650, 4050, 3870, 3690, 3570, 3300},
                '{4200, 3810, 3750, 3690, 3600, 3000},
                '{5600, 5080, 5000, 4920, 4800, 4000}
            };
            custom_mv  = '{4200, 3950, 3850, 3750, 3700, 2800};
            preset_sel = CHEM_CUSTOM;
            mismatches = 0;
        endfunction

        function void apply_write(logic [IDX_W-1:0] idx, logic [VOLT_BITS-1:0] data);
            if (idx == IDX_PRESET) begin
                preset_sel = data[2:0];
            end else if (idx != IDX_UNUSED) begin
                custom_mv[idx - IDX_FULL] = data;
            end
        endfunction

        // breakpoint k (0 = 100 %, 5 = 0 %) of the table in effect
        function int active_mv(int k);
            if (preset_sel >= CHEM_LITHIUM && preset_sel <= CHEM_NIMH4) begin
                return chem_mv[preset_sel - CHEM_LITHIUM][k];
            end
            return custom_mv[k];
        endfunction

        function void note_reading(logic [VOLT_BITS-1:0] mv);
            charge_t exp_c;
            int      v;
            int      seg;
            int      upper;
            int      lower;
            int      pct_hi;
            int      pct;
            v   = mv;
            seg = 4;
            // first band from the top whose lower bound is below v
            for (int k = 3; k >= 0; k--) begin
                if (v > active_mv(k + 1)) seg = k;
            end
            upper  = active_mv(seg);
            lower  = active_mv(seg + 1);
            pct_hi = PCT_FULL - PCT_BAND * seg;
            exp_c.zero_width = (upper == lower);
            if (upper == lower) begin
                pct = pct_hi;
            end else begin
                // integer division truncates toward zero
                pct = (v - upper) * (-PCT_BAND) / (lower - upper) + pct_hi;
            end
            if (pct < 0) pct = 0;
            if (pct > PCT_FULL) pct = PCT_FULL;
            exp_c.percent = pct[6:0];
            expected_charge.push_back(exp_c);
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_charge(logic [6:0] pct, logic zw);
            charge_t exp_c;
            if (expected_charge.size() == 0) begin
                report_mismatch($sformatf("unexpected result percent=%0d zero_width=%b",
                                          pct, zw));
                return;
            end
            exp_c = expected_charge.pop_front();
            if (pct !== exp_c.percent) begin
                report_mismatch($sformatf("percent got %0d expected %0d",
                                          pct, exp_c.percent));
            end
            if (zw !== exp_c.zero_width) begin
                report_mismatch($sformatf("zero_width got %b expected %b",
                                          zw, exp_c.zero_width));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [VOLT_BITS-1:0] cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [VOLT_BITS-1:0] s_millivolts = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [6:0]           m_percent;
    logic                 m_zero_width;

    charge_scoreboard sb;

    // idle-cycle ceilings, changed per phase; zero gives back-to-back traffic
    int tx_gap_max   = 5;
    int rx_stall_max = 5;
    // set by the stimulus to request one long output stall
    bit hold_off_pending = 1'b0;
    int quiet_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    battery_voltage_to_percent #(
        .VOLT_BITS    (VOLT_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_millivolts (s_millivolts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_percent    (m_percent),
        .m_zero_width (m_zero_width)
    );

    // ------------------------------------------------------------------------
    // Drivers. All DUT inputs change by NBA right after a rising edge, and
    // handshakes are judged on the pre-edge values seen at that edge.
    // ------------------------------------------------------------------------

    // One sample transaction. valid is lowered only when a gap is drawn, so a
    // back-to-back sample never sees valid dropped and raised in one step.
    task automatic send_reading(input logic [VOLT_BITS-1:0] mv);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_millivolts <= mv;
        do @(posedge aclk); while (!s_ready);
        sb.note_reading(mv);
    endtask

    // One register write transaction. valid stays high so writes can run
    // back to back; the caller drops it after the last one.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VOLT_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_write(idx, data);
    endtask

    // Stop offering samples and wait until every predicted result is back.
    // Each sample gives exactly one result, so an empty queue means an empty
    // pipeline and the registers may be rewritten.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_charge.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready stalls per transaction, plus one long hold-off
    // on request, counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                stall = $urandom_range(0, rx_stall_max);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_charge(m_percent, m_zero_width);
        end
    end

    // Watchdog: too long without any transaction on any channel is a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                   dir_mv [$];
        int                   mv_q [$];
        bp_shape_t            shape;
        int                   base;
        int                   pick;
        int                   near;
        logic [VOLT_BITS-1:0] pdata;
        logic [VOLT_BITS-1:0] mv;

        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset table, custom preset: field extremes, each breakpoint (upper
        // bounds are inclusive), the first value above 3950 and the first below 2800.
        dir_mv = '{VOLT_MAX, 0, 4200, 3951, 3950, 3850, 3750, 3700, 2800, 2799};
        foreach (dir_mv[i]) send_reading(VOLT_BITS'(dir_mv[i]));
        settle();

        // Zero-width segments at the top and bottom bands; 3400 lands in the
        // 40..20 band with a negative quotient that must truncate toward zero.
        write_reg(IDX_FULL, 3950);
        write_reg(IDX_AT20, 3000);
        write_reg(IDX_EMPTY, 3000);
        cfg_valid <= 1'b0;
        dir_mv = '{4000, 3400, 3000, 0};
        foreach (dir_mv[i]) send_reading(VOLT_BITS'(dir_mv[i]));
        settle();

        // Non-monotonic breakpoints: extrapolation clamps to 0 and to 100.
        write_reg(IDX_FULL, 3900);
        write_reg(IDX_AT20, 3700);
        write_reg(IDX_EMPTY, 3800);
        cfg_valid <= 1'b0;
        send_reading(VOLT_BITS'(VOLT_MAX));
        send_reading(0);
        settle();

        // Each built-in chemistry table.
        for (int p = CHEM_LITHIUM; p <= CHEM_NIMH4; p++) begin
            write_reg(IDX_PRESET, VOLT_BITS'(p));
            cfg_valid <= 1'b0;
            send_reading(3800);
            send_reading(4100);
            settle();
        end

        // Reserved preset with junk in the upper data bits selects the custom
        // registers; a write to the unused index must change nothing.
        write_reg(IDX_PRESET, {11'h7FF, CHEM_RESERVED});
        write_reg(IDX_UNUSED, 14'h2A5C);
        cfg_valid <= 1'b0;
        send_reading(3850);
        send_reading(4500);
        settle();

        // Random phases: new breakpoint table and preset, then a burst of
        // samples, about half of them close to a live breakpoint.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            mv_q.delete();
            shape = bp_shape_t'($urandom_range(0, 5));
            base  = $urandom_range(0, VOLT_MAX - 3);
            for (int k = 0; k < NUM_BP; k++) begin
                case (shape)
                    SHAPE_RESET: begin
                        mv_q.push_back(sb.chem_mv[0][k]);
                    end
                    SHAPE_ZERO: begin
                        mv_q.push_back(0);
                    end
                    SHAPE_MAX: begin
                        mv_q.push_back(VOLT_MAX);
                    end
                    SHAPE_CLUSTER: begin
                        // tiny spread: equal neighbors and zero-width bands
                        mv_q.push_back(base + $urandom_range(0, 3));
                    end
                    default: begin
                        mv_q.push_back($urandom_range(0, VOLT_MAX));
                    end
                endcase
            end
            if (shape == SHAPE_ORDERED || shape == SHAPE_CLUSTER) mv_q.rsort();

            // preset: custom half the time, else any code including reserved
            pdata = VOLT_BITS'($urandom_range(0, VOLT_MAX));
            pdata[2:0] = $urandom_range(0, 1) ? CHEM_CUSTOM : 3'($urandom_range(0, 7));
            write_reg(IDX_PRESET, pdata);
            for (int k = 0; k < NUM_BP; k++) begin
                write_reg(IDX_W'(IDX_FULL + k), VOLT_BITS'(mv_q[k]));
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(IDX_UNUSED, VOLT_BITS'($urandom_range(0, VOLT_MAX)));
            end
            cfg_valid <= 1'b0;

            // every fourth phase runs without idle cycles on either side
            tx_gap_max   = (phase % 4 == 3) ? 0 : 5;
            rx_stall_max = (phase % 4 == 3) ? 0 : 5;
            // two phases stall the output long enough to back up the input
            if (phase == 5 || phase == 21) begin
                hold_off_pending = 1'b1;
                tx_gap_max = 0;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    mv = VOLT_BITS'($urandom_range(0, VOLT_MAX));
                end else if (pick < 9) begin
                    near = sb.active_mv($urandom_range(0, NUM_BP - 1))
                           + $urandom_range(0, 24) - 12;
                    if (near < 0) near = 0;
                    if (near > VOLT_MAX) near = VOLT_MAX;
                    mv = VOLT_BITS'(near);
                end else begin
                    mv = $urandom_range(0, 1) ? VOLT_BITS'(VOLT_MAX) : '0;
                end
                send_reading(mv);
            end
            settle();
        end

        // all results are in; give stray extra results a chance to show up
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/bvp_pkg.sv
rtl/bvp_divider.sv
rtl/battery_voltage_to_percent.sv
test/tb_top.sv
